@@ design/ftms_pkg.sv @@
`default_nettype none

package ftms_pkg;

    localparam int unsigned MARKERS_DEF = 32;

    localparam int unsigned FRAME_W    = 31;
    localparam int unsigned TAG_W      = 32;
    localparam int unsigned DELTA_W    = 32;
    localparam int unsigned SLOT_W     = 5;
    localparam int unsigned STATUS_W   = 2;
    localparam int unsigned OP_W       = 3;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 31;

    typedef enum logic [OP_W-1:0] {
        OP_ADVANCE = 3'd0,
        OP_ADD     = 3'd1,
        OP_PLAY    = 3'd2,
        OP_PAUSE   = 3'd3,
        OP_STOP    = 3'd4
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    localparam logic [CFG_IDX_W-1:0] CFG_DURATION = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP     = 2'd1;

endpackage

`default_nettype wire

@@ design/frame_timeline_marker_scheduler.sv @@
`default_nettype none

// frame playhead with a table of marker compare entries
// input channel (in_valid / in_stall) carries one command request: advance, add marker,
// play, pause or stop. output channel (out_valid / out_stall) returns one result per
// fired marker, or a single result otherwise; last marks the final one of a request.
// configuration (cfg_we, cfg_index, cfg_data) sets the timeline length and looping;
// it is to be written only while the block is idle; the block itself does not enforce this.
// play, pause, stop, add and an advance that moves nothing give their result in the
// cycle after acceptance. a moving advance scans the table, reading each stored marker
// from memory and then comparing it; when the playhead wraps, a bit-serial modulo by
// the duration runs before the scan. one request is worked on at a time; in_stall is low
// only when the sequencer is idle and the result register is free or being taken.
// when the receiver stalls, the result register holds and the scan waits on the next
// fired marker. reset clears the playhead, flags, marker count and fired latches;
// duration resets to 1 and looping off. no clearing pass is needed after reset.
module frame_timeline_marker_scheduler
    import ftms_pkg::*;
#(
    parameter int unsigned MARKERS = MARKERS_DEF
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,

    input  wire logic                         cfg_we,
    input  wire logic [CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [CFG_DATA_W-1:0]        cfg_data,

    input  wire logic                         in_valid,
    output      logic                         in_stall,
    input  wire logic [OP_W-1:0]              opcode,
    input  wire logic signed [DELTA_W-1:0]    frame_step,
    input  wire logic signed [DELTA_W-1:0]    marker_frame,
    input  wire logic signed [TAG_W-1:0]      marker_tag,

    output      logic                         out_valid,
    input  wire logic                         out_stall,
    output      logic [STATUS_W-1:0]          status,
    output      logic                         event_valid,
    output      logic signed [TAG_W-1:0]      event_tag,
    output      logic [SLOT_W-1:0]            marker_slot,
    output      logic [FRAME_W-1:0]           playhead,
    output      logic                         is_playing,
    output      logic                         is_finished,
    output      logic                         last
);

    localparam int unsigned IDX_W = (MARKERS > 1) ? $clog2(MARKERS) : 1;
    localparam int unsigned CNT_W = $clog2(MARKERS + 1);
    localparam int unsigned SUM_W = FRAME_W + 1;
    localparam int unsigned DIV_W = $clog2(SUM_W);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_DIV   = 5'b00010,
        S_READ  = 5'b00100,
        S_TEST  = 5'b01000,
        S_FLUSH = 5'b10000
    } state_t;

    // configuration
    logic [FRAME_W-1:0] dur_reg, dur_next;
    logic               loop_reg, loop_next;

    // timeline state
    logic [FRAME_W-1:0] playhead_reg, playhead_next;
    logic               play_reg, play_next;
    logic               finish_reg, finish_next;
    logic               armed_reg, armed_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [MARKERS-1:0] latch_reg, latch_next;

    // sequencer
    state_t             state_reg, state_next;
    logic [FRAME_W-1:0] before_reg, before_next;
    logic               wrapped_reg, wrapped_next;
    logic               spanned_reg, spanned_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [SUM_W-1:0]   rem_reg, rem_next;
    logic [DIV_W-1:0]   div_cnt_reg, div_cnt_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic               pend_valid_reg, pend_valid_next;
    logic [TAG_W-1:0]   pend_tag_reg, pend_tag_next;

    // result register
    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic                ev_valid_reg, ev_valid_next;
    logic [TAG_W-1:0]    ev_tag_reg, ev_tag_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic [FRAME_W-1:0]  ph_out_reg, ph_out_next;
    logic                playing_reg, playing_next;
    logic                finished_reg, finished_next;
    logic                last_reg, last_next;

    // marker memory
    logic [FRAME_W-1:0] frame_mem [MARKERS];
    logic [TAG_W-1:0]   tag_mem [MARKERS];
    logic [FRAME_W-1:0] rd_frame_reg;
    logic [TAG_W-1:0]   rd_tag_reg;
    logic               mem_we;
    logic [IDX_W-1:0]   wr_addr;
    logic [IDX_W-1:0]   rd_addr;
    logic [FRAME_W-1:0] add_frame;

    logic [FRAME_W-1:0] dur;
    logic               out_free;
    logic               accept;
    logic [SUM_W-1:0]   sum_w;
    logic [SUM_W-1:0]   rem_sh;
    logic [SUM_W-1:0]   rem_step;
    logic               fire;
    logic               latch_cur;
    logic [SLOT_W+CNT_W-1:0] slot_wide;

    // push request into the result register
    logic                push;
    logic [STATUS_W-1:0] push_status;
    logic                push_ev;
    logic [TAG_W-1:0]    push_tag;
    logic [SLOT_W-1:0]   push_slot;
    logic                push_last;

    assign dur      = (dur_reg == '0) ? FRAME_W'(1) : dur_reg;
    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = !((state_reg == S_IDLE) && out_free);
    assign accept   = in_valid && !in_stall;

    assign sum_w    = {1'b0, playhead_reg} + {1'b0, frame_step[FRAME_W-1:0]};
    assign rem_sh   = {rem_reg[SUM_W-2:0], sum_reg[SUM_W-1]};
    assign rem_step = (rem_sh >= {1'b0, dur}) ? (rem_sh - {1'b0, dur}) : rem_sh;

    assign wr_addr   = count_reg[IDX_W-1:0];
    assign rd_addr   = (idx_reg < CNT_W'(MARKERS)) ? idx_reg[IDX_W-1:0] : '0;
    assign add_frame = marker_frame[DELTA_W-1] ? '0 : marker_frame[FRAME_W-1:0];
    assign slot_wide = {{SLOT_W{1'b0}}, count_reg};

    assign latch_cur = latch_reg[idx_reg[IDX_W-1:0]];
    // playhead_reg already holds the updated playhead; a wrap clears the latches beforehand
    assign fire = (!latch_cur && rd_frame_reg > before_reg && rd_frame_reg <= playhead_reg)
               || (armed_reg && !latch_cur && rd_frame_reg == before_reg)
               || (wrapped_reg && (spanned_reg || rd_frame_reg > before_reg
                                   || rd_frame_reg <= playhead_reg));

    always_comb
    begin
        dur_next        = dur_reg;
        loop_next       = loop_reg;
        playhead_next   = playhead_reg;
        play_next       = play_reg;
        finish_next     = finish_reg;
        armed_next      = armed_reg;
        count_next      = count_reg;
        latch_next      = latch_reg;
        state_next      = state_reg;
        before_next     = before_reg;
        wrapped_next    = wrapped_reg;
        spanned_next    = spanned_reg;
        sum_next        = sum_reg;
        rem_next        = rem_reg;
        div_cnt_next    = div_cnt_reg;
        idx_next        = idx_reg;
        pend_valid_next = pend_valid_reg;
        pend_tag_next   = pend_tag_reg;
        mem_we          = 1'b0;
        push            = 1'b0;
        push_status     = ST_OK;
        push_ev         = 1'b0;
        push_tag        = '0;
        push_slot       = '0;
        push_last       = 1'b1;

        if (cfg_we)
        begin
            case (cfg_index)
                CFG_DURATION: dur_next  = cfg_data[FRAME_W-1:0];
                CFG_LOOP:     loop_next = cfg_data[0];
                default:      ;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (opcode)
                        OP_ADVANCE:
                        begin
                            if (frame_step <= 32'sd0 || !play_reg || finish_reg)
                            begin
                                push = 1'b1;
                            end
                            else
                            begin
                                before_next     = playhead_reg;
                                spanned_next    = frame_step[FRAME_W-1:0] >= dur;
                                wrapped_next    = 1'b0;
                                pend_valid_next = 1'b0;
                                idx_next        = '0;
                                state_next      = S_READ;
                                if (sum_w >= {1'b0, dur})
                                begin
                                    if (loop_reg)
                                    begin
                                        wrapped_next = 1'b1;
                                        latch_next   = '0;
                                        sum_next     = sum_w;
                                        rem_next     = '0;
                                        div_cnt_next = DIV_W'(SUM_W - 1);
                                        state_next   = S_DIV;
                                    end
                                    else
                                    begin
                                        playhead_next = dur;
                                        finish_next   = 1'b1;
                                        play_next     = 1'b0;
                                    end
                                end
                                else
                                begin
                                    playhead_next = sum_w[FRAME_W-1:0];
                                end
                            end
                        end
                        OP_ADD:
                        begin
                            push = 1'b1;
                            if (count_reg >= CNT_W'(MARKERS))
                            begin
                                push_status = ST_FULL;
                            end
                            else if (!marker_frame[DELTA_W-1]
                                     && marker_frame[FRAME_W-1:0] > dur)
                            begin
                                push_status = ST_RANGE;
                            end
                            else
                            begin
                                mem_we              = 1'b1;
                                latch_next[wr_addr] = 1'b0;
                                count_next          = count_reg + CNT_W'(1);
                                push_slot           = slot_wide[SLOT_W-1:0];
                            end
                        end
                        OP_PLAY:
                        begin
                            push        = 1'b1;
                            play_next   = 1'b1;
                            finish_next = 1'b0;
                            armed_next  = (playhead_reg == '0);
                        end
                        OP_PAUSE:
                        begin
                            push      = 1'b1;
                            play_next = 1'b0;
                        end
                        OP_STOP:
                        begin
                            push          = 1'b1;
                            play_next     = 1'b0;
                            finish_next   = 1'b0;
                            playhead_next = '0;
                            armed_next    = 1'b0;
                            latch_next    = '0;
                        end
                        default:
                        begin
                            push = 1'b1;
                        end
                    endcase
                end
            end

            // one dividend bit per cycle, most significant first
            S_DIV:
            begin
                rem_next = rem_step;
                sum_next = {sum_reg[SUM_W-2:0], 1'b0};
                if (div_cnt_reg == '0)
                begin
                    playhead_next = rem_step[FRAME_W-1:0];
                    state_next    = S_READ;
                end
                else
                begin
                    div_cnt_next = div_cnt_reg - DIV_W'(1);
                end
            end

            S_READ:
            begin
                if (idx_reg == count_reg)
                    state_next = S_FLUSH;
                else
                    state_next = S_TEST;
            end

            // a fired marker is held back until the next one shows whether it is last
            S_TEST:
            begin
                if (!fire)
                begin
                    idx_next   = idx_reg + CNT_W'(1);
                    state_next = S_READ;
                end
                else if (!pend_valid_reg || out_free)
                begin
                    if (pend_valid_reg)
                    begin
                        push      = 1'b1;
                        push_ev   = 1'b1;
                        push_tag  = pend_tag_reg;
                        push_last = 1'b0;
                    end
                    pend_valid_next                  = 1'b1;
                    pend_tag_next                    = rd_tag_reg;
                    latch_next[idx_reg[IDX_W-1:0]]   = 1'b1;
                    idx_next                         = idx_reg + CNT_W'(1);
                    state_next                       = S_READ;
                end
            end

            S_FLUSH:
            begin
                if (out_free)
                begin
                    push       = 1'b1;
                    push_ev    = pend_valid_reg;
                    push_tag   = pend_valid_reg ? pend_tag_reg : '0;
                    armed_next = 1'b0;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        out_valid_next = out_valid_reg && out_stall;
        status_next    = status_reg;
        ev_valid_next  = ev_valid_reg;
        ev_tag_next    = ev_tag_reg;
        slot_next      = slot_reg;
        ph_out_next    = ph_out_reg;
        playing_next   = playing_reg;
        finished_next  = finished_reg;
        last_next      = last_reg;
        if (push)
        begin
            out_valid_next = 1'b1;
            status_next    = push_status;
            ev_valid_next  = push_ev;
            ev_tag_next    = push_tag;
            slot_next      = push_slot;
            ph_out_next    = playhead_next;
            playing_next   = play_next;
            finished_next  = finish_next;
            last_next      = push_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dur_reg        <= FRAME_W'(1);
            loop_reg       <= 1'b0;
            playhead_reg   <= '0;
            play_reg       <= 1'b0;
            finish_reg     <= 1'b0;
            armed_reg      <= 1'b0;
            count_reg      <= '0;
            latch_reg      <= '0;
            state_reg      <= S_IDLE;
            div_cnt_reg    <= '0;
            idx_reg        <= '0;
            pend_valid_reg <= 1'b0;
            wrapped_reg    <= 1'b0;
            spanned_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            dur_reg        <= dur_next;
            loop_reg       <= loop_next;
            playhead_reg   <= playhead_next;
            play_reg       <= play_next;
            finish_reg     <= finish_next;
            armed_reg      <= armed_next;
            count_reg      <= count_next;
            latch_reg      <= latch_next;
            state_reg      <= state_next;
            div_cnt_reg    <= div_cnt_next;
            idx_reg        <= idx_next;
            pend_valid_reg <= pend_valid_next;
            wrapped_reg    <= wrapped_next;
            spanned_reg    <= spanned_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        before_reg   <= before_next;
        sum_reg      <= sum_next;
        rem_reg      <= rem_next;
        pend_tag_reg <= pend_tag_next;
        status_reg   <= status_next;
        ev_valid_reg <= ev_valid_next;
        ev_tag_reg   <= ev_tag_next;
        slot_reg     <= slot_next;
        ph_out_reg   <= ph_out_next;
        playing_reg  <= playing_next;
        finished_reg <= finished_next;
        last_reg     <= last_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            frame_mem[wr_addr] <= add_frame;
            tag_mem[wr_addr]   <= marker_tag;
        end
        rd_frame_reg <= frame_mem[rd_addr];
        rd_tag_reg   <= tag_mem[rd_addr];
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign event_valid = ev_valid_reg;
    assign event_tag   = ev_tag_reg;
    assign marker_slot = slot_reg;
    assign playhead    = ph_out_reg;
    assign is_playing  = playing_reg;
    assign is_finished = finished_reg;
    assign last        = last_reg;

    // a request is only taken by an idle sequencer with room for its result
    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |-> state_reg == S_IDLE && out_free)
        else $error("request accepted while busy");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MARKERS))
        else $error("marker count beyond table size");

    // partial remainder stays below the duration throughout the modulo
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |-> rem_reg < {1'b0, dur})
        else $error("modulo remainder out of range");

    a_event_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_valid |-> status == ST_OK && marker_slot == '0)
        else $error("marker event with non-ok status or slot");

    a_scan_done: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FLUSH && out_free |=> state_reg == S_IDLE && out_valid && last)
        else $error("advance did not close with a last result");

endmodule

`default_nettype wire
